// File: hdl/fsgp_pkg.sv
package fsgp_pkg;

    // grid defaults
    localparam int GRID_W_DEF = 64;
    localparam int GRID_H_DEF = 64;

    // field widths
    localparam int CELL_W   = 8;
    localparam int COORD_W  = 6;
    localparam int FUNC_W   = 2;
    localparam int MOVES_W  = 13;
    localparam int DIM_W    = 7;
    localparam int LFSR_W   = 16;

    // configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // dimension limits
    localparam int MIN_COLS = 2;
    localparam int MIN_ROWS = 3;

    // register reset values
    localparam logic [DIM_W-1:0]  WIDTH_RST  = 7'd64;
    localparam logic [DIM_W-1:0]  HEIGHT_RST = 7'd64;
    localparam logic [CELL_W-1:0] VOID_RST   = 8'd0;
    localparam logic [CELL_W-1:0] SAND_RST   = 8'd1;
    localparam logic [CELL_W-1:0] WATER_RST  = 8'd2;
    localparam logic [LFSR_W-1:0] SEED_RST   = 16'd44257;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_VOID   = 3'd2,
        REG_SAND   = 3'd3,
        REG_WATER  = 3'd4,
        REG_SEED   = 3'd5
    } reg_idx_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_PASS  = 2'd2
    } func_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RDATA,
        S_CHK_SRC,
        S_GOT_D,
        S_GOT_L,
        S_GOT_R,
        S_WR2,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [DIM_W-1:0]  width_in_use;
        logic [DIM_W-1:0]  height_in_use;
        logic [CELL_W-1:0] void_code;
        logic [CELL_W-1:0] sand_code;
        logic [CELL_W-1:0] water_code;
        logic [LFSR_W-1:0] random_seed;
        logic              seed_load;
        logic [LFSR_W-1:0] seed_data;
    } cfg_t;

    // clamp a dimension register into [lo, hi]
    function automatic int clamp_dim(logic [DIM_W-1:0] v, int lo, int hi);
        int r;
        r = int'(v);
        if (r < lo)
        begin
            r = lo;
        end
        if (r > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

// File: hdl/fsgp_if.sv
interface fsgp_cmd_if import fsgp_pkg::*;;
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [CELL_W-1:0]  cell_value;

    modport source (output valid, func, cell_x, cell_y, cell_value, input ready);
    modport sink   (input valid, func, cell_x, cell_y, cell_value, output ready);
endinterface

interface fsgp_rsp_if import fsgp_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CELL_W-1:0]  read_value;
    logic               pass_done;
    logic [MOVES_W-1:0] moves_made;

    modport source (output valid, read_value, pass_done, moves_made, input ready);
    modport sink   (input valid, read_value, pass_done, moves_made, output ready);
endinterface

// File: hdl/fsgp_ram.sv
module fsgp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/fsgp_regs.sv
module fsgp_regs import fsgp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output cfg_t              cfg
);

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [CELL_W-1:0] void_reg;
    logic [CELL_W-1:0] sand_reg;
    logic [CELL_W-1:0] water_reg;
    logic [LFSR_W-1:0] seed_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            void_reg   <= VOID_RST;
            sand_reg   <= SAND_RST;
            water_reg  <= WATER_RST;
            seed_reg   <= SEED_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_VOID:   void_reg   <= pwdata[CELL_W-1:0];
                REG_SAND:   sand_reg   <= pwdata[CELL_W-1:0];
                REG_WATER:  water_reg  <= pwdata[CELL_W-1:0];
                REG_SEED:   seed_reg   <= pwdata[LFSR_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_WIDTH:  prdata = APB_DW'(width_reg);
            REG_HEIGHT: prdata = APB_DW'(height_reg);
            REG_VOID:   prdata = APB_DW'(void_reg);
            REG_SAND:   prdata = APB_DW'(sand_reg);
            REG_WATER:  prdata = APB_DW'(water_reg);
            REG_SEED:   prdata = APB_DW'(seed_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.width_in_use  = width_reg;
    assign cfg.height_in_use = height_reg;
    assign cfg.void_code     = void_reg;
    assign cfg.sand_code     = sand_reg;
    assign cfg.water_code    = water_reg;
    assign cfg.random_seed   = seed_reg;
    assign cfg.seed_load     = wr_en && (idx == REG_SEED);
    assign cfg.seed_data     = pwdata[LFSR_W-1:0];

endmodule

// File: hdl/falling_sand_grid_pass.sv
// falling_sand_grid_pass: grid of 8-bit cell codes with an in-place falling sand pass
//
// cmd channel (valid/ready) carries one transaction per operation: write a cell,
// read a cell, or run one pass over the grid. rsp channel returns exactly one
// transaction per command, in order: read_value for a read, pass_done and
// moves_made for a pass, all zero otherwise.
// the APB port sets grid size, the void/sand/water codes and the tie-break seed;
// the user must see that it is written only while no command is in flight; the block
// itself does not enforce this. pready is always high. a pass walks the grid through
// the single read port of the grid memory: a non-sand cell is passed over at once; for
// a sand cell it reads below, below-left and below-right, then writes source and
// target if the sand moves; the read of the next cell overlaps the target write, or
// the move decision when the sand stays.
// one command is worked at a time; a new command is taken while the previous
// result still waits in the output register.
// when the receiver stalls, the finished result is held in a done state until
// the output register frees up. reset clears the control state and loads the
// LFSR with the seed reset value; grid memory content is undefined until written.
module falling_sand_grid_pass import fsgp_pkg::*; #(
    parameter int GRID_W = GRID_W_DEF,
    parameter int GRID_H = GRID_H_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    fsgp_cmd_if.sink          cmd,
    fsgp_rsp_if.source        rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int XW    = $clog2(GRID_W);
    localparam int YW    = $clog2(GRID_H);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 2 ** AW;

    cfg_t cfg;

    state_t state_reg, state_next;

    // latched command
    logic [FUNC_W-1:0]  func_reg, func_next;
    logic [COORD_W-1:0] cx_reg, cx_next;
    logic [COORD_W-1:0] cy_reg, cy_next;
    logic [CELL_W-1:0]  cval_reg, cval_next;

    // pass scan position and neighbor capture
    logic [XW-1:0]      x_reg, x_next;
    logic [YW-1:0]      y_reg, y_next;
    logic [CELL_W-1:0]  dn_reg, dn_next;
    logic [CELL_W-1:0]  lf_reg, lf_next;
    logic [AW-1:0]      tgt_reg, tgt_next;
    logic [LFSR_W-1:0]  lfsr_reg, lfsr_next;

    // result under construction
    logic [CELL_W-1:0]  rv_reg, rv_next;
    logic               done_reg, done_next;
    logic [MOVES_W-1:0] moves_reg, moves_next;

    // output register
    logic               ov_reg, ov_next;
    logic [CELL_W-1:0]  o_rv_reg, o_rv_next;
    logic               o_done_reg, o_done_next;
    logic [MOVES_W-1:0] o_moves_reg, o_moves_next;
    logic               out_load;

    // grid memory port
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [CELL_W-1:0]  ram_wdata, ram_rdata;

    // derived geometry
    logic [XW-1:0]      x_last;
    logic [YW-1:0]      y_first;
    logic               in_area;
    logic [AW-1:0]      item_addr;
    logic [AW-1:0]      src_addr, dn_addr, lf_addr, rt_addr;
    logic [XW-1:0]      nx;
    logic [YW-1:0]      ny;
    logic               pass_last;
    logic               is_sand;

    // move decision
    logic               left_ok;
    logic               vd, vl, vr, wd, wl, wr;
    logic               use_void, m_d, m_l, m_r, moving, tie, fb;
    logic [CELL_W-1:0]  fill_code;
    logic [XW-1:0]      tx;

    fsgp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    fsgp_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // effective size: last scanned column is W-2, first scanned row is H-3
    assign x_last  = XW'(clamp_dim(cfg.width_in_use, MIN_COLS, GRID_W) - MIN_COLS);
    assign y_first = YW'(clamp_dim(cfg.height_in_use, MIN_ROWS, GRID_H) - MIN_ROWS);
    assign in_area = (int'(cx_reg) < clamp_dim(cfg.width_in_use, MIN_COLS, GRID_W))
                  && (int'(cy_reg) < clamp_dim(cfg.height_in_use, MIN_ROWS, GRID_H));

    // memory address is row then column
    assign item_addr = {YW'(cy_reg), XW'(cx_reg)};
    assign src_addr  = {y_reg, x_reg};
    assign dn_addr   = {y_reg + YW'(1), x_reg};
    assign lf_addr   = {y_reg + YW'(1), x_reg - XW'(1)};
    assign rt_addr   = {y_reg + YW'(1), x_reg + XW'(1)};

    // scan order: columns left to right, rows bottom to top
    assign pass_last = (x_reg == x_last) && (y_reg == '0);
    assign nx        = (x_reg == x_last) ? '0 : x_reg + XW'(1);
    assign ny        = (x_reg == x_last) ? y_reg - YW'(1) : y_reg;
    assign is_sand   = (ram_rdata == cfg.sand_code);

    // neighbors: below in dn_reg, below-left in lf_reg, below-right on the read bus
    assign left_ok   = (x_reg != '0);
    assign vd        = (dn_reg == cfg.void_code);
    assign vl        = left_ok && (lf_reg == cfg.void_code);
    assign vr        = (ram_rdata == cfg.void_code);
    assign wd        = (dn_reg == cfg.water_code);
    assign wl        = left_ok && (lf_reg == cfg.water_code);
    assign wr        = (ram_rdata == cfg.water_code);
    // void is tried first, water only when no void neighbor exists
    assign use_void  = vd || vl || vr;
    assign m_d       = use_void ? vd : wd;
    assign m_l       = use_void ? vl : wl;
    assign m_r       = use_void ? vr : wr;
    assign fill_code = use_void ? cfg.void_code : cfg.water_code;
    assign moving    = m_d || m_l || m_r;
    assign tie       = !m_d && m_l && m_r;
    assign fb        = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];

    always_comb
    begin
        if (m_d)
        begin
            tx = x_reg;
        end
        else if (tie)
        begin
            tx = fb ? x_reg + XW'(1) : x_reg - XW'(1);
        end
        else if (m_l)
        begin
            tx = x_reg - XW'(1);
        end
        else
        begin
            tx = x_reg + XW'(1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (func_reg)
                    FUNC_READ: state_next = S_RDATA;
                    FUNC_PASS: state_next = S_CHK_SRC;
                    default:   state_next = S_DONE;
                endcase
            end
            S_RDATA:
            begin
                state_next = S_DONE;
            end
            S_CHK_SRC:
            begin
                if (is_sand)
                begin
                    state_next = S_GOT_D;
                end
                else if (pass_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_GOT_D:
            begin
                state_next = S_GOT_L;
            end
            S_GOT_L:
            begin
                state_next = S_GOT_R;
            end
            S_GOT_R:
            begin
                if (moving)
                begin
                    state_next = S_WR2;
                end
                else if (pass_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_CHK_SRC;
                end
            end
            S_WR2:
            begin
                state_next = pass_last ? S_DONE : S_CHK_SRC;
            end
            S_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cmd.ready  = 1'b0;
        func_next  = func_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cval_next  = cval_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        dn_next    = dn_reg;
        lf_next    = lf_reg;
        tgt_next   = tgt_reg;
        rv_next    = rv_reg;
        done_next  = done_reg;
        moves_next = moves_reg;
        lfsr_next  = lfsr_reg;
        ram_re     = 1'b0;
        ram_raddr  = src_addr;
        ram_we     = 1'b0;
        ram_waddr  = src_addr;
        ram_wdata  = cfg.sand_code;
        out_load   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    func_next = cmd.func;
                    cx_next   = cmd.cell_x;
                    cy_next   = cmd.cell_y;
                    cval_next = cmd.cell_value;
                end
            end
            S_EXEC:
            begin
                rv_next    = '0;
                moves_next = '0;
                done_next  = (func_reg == FUNC_PASS);
                case (func_reg)
                    FUNC_WRITE:
                    begin
                        ram_we    = in_area;
                        ram_waddr = item_addr;
                        ram_wdata = cval_reg;
                    end
                    FUNC_READ:
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = item_addr;
                    end
                    FUNC_PASS:
                    begin
                        x_next    = '0;
                        y_next    = y_first;
                        ram_re    = 1'b1;
                        ram_raddr = {y_first, XW'(0)};
                    end
                    default: ;
                endcase
            end
            S_RDATA:
            begin
                rv_next = in_area ? ram_rdata : '0;
            end
            S_CHK_SRC:
            begin
                ram_re = 1'b1;
                if (is_sand)
                begin
                    ram_raddr = dn_addr;
                end
                else
                begin
                    // skip to the next cell at once
                    ram_re    = !pass_last;
                    ram_raddr = {ny, nx};
                    x_next    = pass_last ? x_reg : nx;
                    y_next    = pass_last ? y_reg : ny;
                end
            end
            S_GOT_D:
            begin
                dn_next   = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = lf_addr;
            end
            S_GOT_L:
            begin
                lf_next   = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = rt_addr;
            end
            S_GOT_R:
            begin
                if (moving)
                begin
                    // source takes the code it trades with
                    ram_we    = 1'b1;
                    ram_waddr = src_addr;
                    ram_wdata = fill_code;
                    tgt_next  = {y_reg + YW'(1), tx};
                    if (tie)
                    begin
                        lfsr_next = {fb, lfsr_reg[LFSR_W-1:1]};
                    end
                end
                else if (!pass_last)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = {ny, nx};
                    x_next    = nx;
                    y_next    = ny;
                end
            end
            S_WR2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = tgt_reg;
                ram_wdata  = cfg.sand_code;
                moves_next = moves_reg + MOVES_W'(1);
                if (!pass_last)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = {ny, nx};
                    x_next    = nx;
                    y_next    = ny;
                end
            end
            S_DONE:
            begin
                out_load = !ov_reg || rsp.ready;
            end
            default: ;
        endcase

        // seed writes reload the LFSR, a zero seed loads as one
        if (cfg.seed_load)
        begin
            lfsr_next = (cfg.seed_data == '0) ? LFSR_W'(1) : cfg.seed_data;
        end
    end

    // output register, refilled when empty or being drained
    assign ov_next      = out_load ? 1'b1 : ((ov_reg && rsp.ready) ? 1'b0 : ov_reg);
    assign o_rv_next    = out_load ? rv_reg : o_rv_reg;
    assign o_done_next  = out_load ? done_reg : o_done_reg;
    assign o_moves_next = out_load ? moves_reg : o_moves_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            lfsr_reg  <= SEED_RST;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            lfsr_reg  <= lfsr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cval_reg    <= cval_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        dn_reg      <= dn_next;
        lf_reg      <= lf_next;
        tgt_reg     <= tgt_next;
        rv_reg      <= rv_next;
        done_reg    <= done_next;
        moves_reg   <= moves_next;
        o_rv_reg    <= o_rv_next;
        o_done_reg  <= o_done_next;
        o_moves_reg <= o_moves_next;
    end

    assign rsp.valid      = ov_reg;
    assign rsp.read_value = o_rv_reg;
    assign rsp.pass_done  = o_done_reg;
    assign rsp.moves_made = o_moves_reg;

    // a write and a read of the same grid cell never share a cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("grid read and write hit the same cell");

    // the tie-break LFSR never locks up at zero
    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("tie-break lfsr reached zero");

    // the target write always follows the source write of the same move
    a_wr2_after_move: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR2) |-> ($past(state_reg) == S_GOT_R))
        else $error("target write without a source write");

    // scan position stays inside the active area during a pass
    a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK_SRC) |-> ((x_reg <= x_last) && (y_reg <= y_first)))
        else $error("pass scan left the active area");

endmodule

// File: tb/tb_falling_sand_grid_pass.sv
module tb_falling_sand_grid_pass import fsgp_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // grid geometry of the instance under test
    localparam int GRID_CELLS = GRID_W_DEF * GRID_H_DEF;

    // painted corner that every pass stays within
    localparam int FILL_COLS = 6;
    localparam int FILL_ROWS = 6;

    // func code with no operation behind it
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    // run limits
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 50;

    // one response transaction as predicted
    typedef struct {
        logic [CELL_W-1:0]  read_value;
        logic               pass_done;
        logic [MOVES_W-1:0] moves_made;
    } grid_reply_t;

    logic clk;
    logic rst_n;

    // apb configuration port
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    fsgp_cmd_if cmd_bus ();
    fsgp_rsp_if rsp_bus ();

    falling_sand_grid_pass dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_bus),
        .rsp     (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of the grid and of the register file
    logic [CELL_W-1:0] shadow_grid [GRID_CELLS];
    logic [DIM_W-1:0]  cfg_cols;
    logic [DIM_W-1:0]  cfg_rows;
    logic [CELL_W-1:0] code_void;
    logic [CELL_W-1:0] code_sand;
    logic [CELL_W-1:0] code_water;
    logic [LFSR_W-1:0] tie_state;

    // responses still owed by the block, oldest first
    grid_reply_t expected_replies [$];

    int  err_count;
    int  reply_count;
    int  cycle_count;
    int  stall_left;
    bit  gaps_on;
    bit  stalls_on;

    // free-running clock, 10 ns period
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // column count after clamping into the legal range
    function automatic int used_cols();
        int c;
        c = int'(cfg_cols);
        if (c < MIN_COLS)
        begin
            c = MIN_COLS;
        end
        if (c > GRID_W_DEF)
        begin
            c = GRID_W_DEF;
        end
        return c;
    endfunction

    // row count after clamping into the legal range
    function automatic int used_rows();
        int r;
        r = int'(cfg_rows);
        if (r < MIN_ROWS)
        begin
            r = MIN_ROWS;
        end
        if (r > GRID_H_DEF)
        begin
            r = GRID_H_DEF;
        end
        return r;
    endfunction

    function automatic int grid_slot(int x, int y);
        return y * GRID_W_DEF + x;
    endfunction

    // one lfsr step per tie, the feedback bit picks the side (1 = right)
    function automatic bit tie_pick_right();
        logic fb;
        fb = tie_state[0] ^ tie_state[2] ^ tie_state[3] ^ tie_state[5];
        tie_state = {fb, tie_state[LFSR_W-1:1]};
        return fb;
    endfunction

    // move the sand at (x,y) into a lower neighbor holding target, if any
    function automatic bit sand_slide(int x, int y, logic [CELL_W-1:0] target);
        bit dn;
        bit lf;
        bit rt;
        int tx;
        dn = shadow_grid[grid_slot(x, y + 1)] == target;
        lf = (x > 0) && (shadow_grid[grid_slot(x - 1, y + 1)] == target);
        rt = shadow_grid[grid_slot(x + 1, y + 1)] == target;
        if (dn)
        begin
            tx = x;
        end
        else if (lf && rt)
        begin
            tx = tie_pick_right() ? x + 1 : x - 1;
        end
        else if (lf)
        begin
            tx = x - 1;
        end
        else if (rt)
        begin
            tx = x + 1;
        end
        else
        begin
            return 1'b0;
        end
        // void is left behind, water trades places
        shadow_grid[grid_slot(x, y)] = target;
        shadow_grid[grid_slot(tx, y + 1)] = code_sand;
        return 1'b1;
    endfunction

    // bottom-up sweep, skipping the last two rows and the last column
    function automatic int sand_sweep();
        int cols;
        int rows;
        int moves;
        cols = used_cols();
        rows = used_rows();
        moves = 0;
        for (int y = rows - 3; y >= 0; y--)
        begin
            for (int x = 0; x + 1 < cols; x++)
            begin
                if (shadow_grid[grid_slot(x, y)] == code_sand)
                begin
                    if (sand_slide(x, y, code_void))
                    begin
                        moves++;
                    end
                    else if (sand_slide(x, y, code_water))
                    begin
                        moves++;
                    end
                end
            end
        end
        return moves;
    endfunction

    // apply one command to the shadow grid and return the response it owes
    function automatic grid_reply_t grid_apply(logic [FUNC_W-1:0] op, logic [COORD_W-1:0] x,
                                               logic [COORD_W-1:0] y, logic [CELL_W-1:0] v);
        grid_reply_t r;
        bit in_area;
        r.read_value = '0;
        r.pass_done  = 1'b0;
        r.moves_made = '0;
        in_area = (int'(x) < used_cols()) && (int'(y) < used_rows());
        case (op)
            FUNC_WRITE:
            begin
                if (in_area)
                begin
                    shadow_grid[grid_slot(int'(x), int'(y))] = v;
                end
            end
            FUNC_READ:
            begin
                if (in_area)
                begin
                    r.read_value = shadow_grid[grid_slot(int'(x), int'(y))];
                end
            end
            FUNC_PASS:
            begin
                r.moves_made = MOVES_W'(sand_sweep());
                r.pass_done  = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // reporting and checking
    // ------------------------------------------------------------------

    // one line per mismatch
    task automatic note_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    // compare every accepted response transaction against the oldest prediction
    always @(posedge clk)
    begin
        grid_reply_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_replies.size() == 0)
            begin
                note_mismatch($sformatf("reply %0d arrived with nothing pending", reply_count));
            end
            else
            begin
                want = expected_replies.pop_front();
                if (rsp_bus.read_value !== want.read_value)
                begin
                    note_mismatch($sformatf("reply %0d read_value got %0h want %0h",
                                            reply_count, rsp_bus.read_value, want.read_value));
                end
                if (rsp_bus.pass_done !== want.pass_done)
                begin
                    note_mismatch($sformatf("reply %0d pass_done got %0b want %0b",
                                            reply_count, rsp_bus.pass_done, want.pass_done));
                end
                if (rsp_bus.moves_made !== want.moves_made)
                begin
                    note_mismatch($sformatf("reply %0d moves_made got %0d want %0d",
                                            reply_count, rsp_bus.moves_made, want.moves_made));
                end
            end
            reply_count++;
        end
    end

    // ------------------------------------------------------------------
    // traffic shaping
    // ------------------------------------------------------------------

    // mostly short idles, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // response back-pressure, one assignment per falling edge
    initial
    begin
        rsp_bus.ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                if (stalls_on && $urandom_range(0, 99) < 25)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // run limit: a hung block ends the run here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("falling_sand_grid_pass regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // send one command transaction; prediction is taken at the accepting edge
    task automatic send_op(logic [FUNC_W-1:0] op, int x, int y, int v);
        int gap;
        gap = (gaps_on && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            cmd_bus.valid <= 1'b0;
        end
        @(negedge clk);
        cmd_bus.valid      <= 1'b1;
        cmd_bus.func       <= op;
        cmd_bus.cell_x     <= COORD_W'(x);
        cmd_bus.cell_y     <= COORD_W'(y);
        cmd_bus.cell_value <= CELL_W'(v);
        do
        begin
            @(posedge clk);
        end
        while (!cmd_bus.ready);
        expected_replies.push_back(grid_apply(op, COORD_W'(x), COORD_W'(y), CELL_W'(v)));
    endtask

    // hold the command side off until every owed reply is back
    task automatic drain_replies();
        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        while (expected_replies.size() != 0)
        begin
            @(posedge clk);
        end
        // let the block settle back to idle
        repeat (4)
        begin
            @(posedge clk);
        end
    endtask

    // two-phase apb write, register lands when the access phase is accepted
    task automatic apb_write(reg_idx_t idx, logic [APB_DW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(int'(idx) * 4);
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        case (idx)
            REG_WIDTH:  cfg_cols   = data[DIM_W-1:0];
            REG_HEIGHT: cfg_rows   = data[DIM_W-1:0];
            REG_VOID:   code_void  = data[CELL_W-1:0];
            REG_SAND:   code_sand  = data[CELL_W-1:0];
            REG_WATER:  code_water = data[CELL_W-1:0];
            // a zero seed would lock the lfsr, so it loads as one
            REG_SEED:   tie_state  = (data[LFSR_W-1:0] == '0) ? LFSR_W'(1) : data[LFSR_W-1:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // size and codes are only touched with nothing in flight
    task automatic program_regs(int cols, int rows, int vcode, int scode, int wcode);
        drain_replies();
        apb_write(REG_WIDTH,  APB_DW'(cols));
        apb_write(REG_HEIGHT, APB_DW'(rows));
        apb_write(REG_VOID,   APB_DW'(vcode));
        apb_write(REG_SAND,   APB_DW'(scode));
        apb_write(REG_WATER,  APB_DW'(wcode));
    endtask

    task automatic program_seed(int seed);
        drain_replies();
        apb_write(REG_SEED, APB_DW'(seed));
    endtask

    // a random cell code leaning toward the three material codes
    function automatic int pick_material();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            return int'(code_sand);
        end
        if (r < 65)
        begin
            return int'(code_void);
        end
        if (r < 85)
        begin
            return int'(code_water);
        end
        return $urandom_range(0, 255);
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // paint the top-left corner so no pass or read there ever sees an unwritten cell
    task automatic test_grid_fill();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        for (int y = 0; y < FILL_ROWS; y++)
        begin
            for (int x = 0; x < FILL_COLS; x++)
            begin
                send_op(FUNC_WRITE, x, y, pick_material());
            end
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    // corner cells with all-ones and all-zeros data, plus the spare func code
    task automatic test_cell_access();
        send_op(FUNC_WRITE, 0, 0, 8'hFF);
        send_op(FUNC_WRITE, 63, 63, 8'h00);
        send_op(FUNC_WRITE, 63, 0, 8'hA5);
        send_op(FUNC_WRITE, 0, 63, 8'h5A);
        send_op(FUNC_READ, 0, 0, 0);
        send_op(FUNC_READ, 63, 63, 8'hFF);
        send_op(FUNC_READ, 63, 0, 0);
        send_op(FUNC_READ, 0, 63, 0);
        send_op(FUNC_SPARE, 63, 63, 8'hFF);
    endtask

    // one pass over the whole painted corner
    task automatic test_full_pass();
        program_regs(FILL_COLS, FILL_ROWS, 0, 1, 2);
        send_op(FUNC_PASS, 0, 0, 0);
    endtask

    // sizes below and above the legal range clamp; cells outside are ignored
    task automatic test_size_clamp();
        program_regs(1, 2, 0, 1, 2);
        send_op(FUNC_WRITE, 5, 1, 1);
        send_op(FUNC_READ, 5, 1, 0);
        send_op(FUNC_READ, 1, 2, 0);
        send_op(FUNC_PASS, 0, 0, 0);
        program_regs(127, 127, 0, 1, 2);
        send_op(FUNC_WRITE, 63, 62, 8'h3C);
        send_op(FUNC_READ, 63, 62, 0);
    endtask

    // both diagonals open under a blocked sand grain, zero seed loaded
    task automatic test_tie_break();
        program_regs(3, 3, 0, 1, 2);
        program_seed(0);
        send_op(FUNC_WRITE, 0, 0, 2);
        send_op(FUNC_WRITE, 1, 0, 1);
        send_op(FUNC_WRITE, 1, 1, 1);
        send_op(FUNC_WRITE, 0, 1, 0);
        send_op(FUNC_WRITE, 2, 1, 0);
        send_op(FUNC_PASS, 0, 0, 0);
        send_op(FUNC_READ, 0, 1, 0);
        // rebuild the same tie for the next lfsr bit
        send_op(FUNC_WRITE, 1, 0, 1);
        send_op(FUNC_WRITE, 0, 1, 0);
        send_op(FUNC_WRITE, 2, 1, 0);
        send_op(FUNC_PASS, 0, 0, 0);
        send_op(FUNC_READ, 2, 1, 0);
    endtask

    // sand over water trades places, with the all-ones seed
    task automatic test_water_swap();
        program_regs(4, 4, 0, 1, 2);
        program_seed(16'hFFFF);
        send_op(FUNC_WRITE, 1, 0, 1);
        send_op(FUNC_WRITE, 1, 1, 2);
        send_op(FUNC_WRITE, 0, 1, 1);
        send_op(FUNC_WRITE, 2, 1, 1);
        send_op(FUNC_PASS, 0, 0, 0);
        send_op(FUNC_READ, 1, 0, 0);
    endtask

    // void, sand and water share one code
    task automatic test_equal_codes();
        program_regs(5, 5, 255, 255, 255);
        send_op(FUNC_WRITE, 2, 1, 255);
        send_op(FUNC_PASS, 0, 0, 0);
    endtask

    // random settings, each phase paints a scene and then mixes passes and reads
    task automatic test_random_scenes();
        int sz;
        int cd;
        int cols;
        int rows;
        int vc;
        int sc;
        int wc;
        int op;
        for (int phase = 0; phase < 3; phase++)
        begin
            // every third phase runs flat out on both sides
            gaps_on = (phase % 3) != 2;
            stalls_on = (phase % 3) != 2;
            sz = $urandom_range(0, 9);
            case (sz)
                0:
                begin
                    cols = FILL_COLS;
                    rows = $urandom_range(3, FILL_ROWS);
                end
                1:
                begin
                    cols = $urandom_range(2, FILL_COLS);
                    rows = FILL_ROWS;
                end
                2:
                begin
                    cols = $urandom_range(0, 1);
                    rows = $urandom_range(0, 2);
                end
                3:
                begin
                    cols = $urandom_range(0, 1);
                    rows = $urandom_range(3, FILL_ROWS);
                end
                default:
                begin
                    cols = $urandom_range(2, FILL_COLS);
                    rows = $urandom_range(3, FILL_ROWS);
                end
            endcase
            cd = $urandom_range(0, 3);
            case (cd)
                0:
                begin
                    vc = 0;
                    sc = 1;
                    wc = 2;
                end
                1:
                begin
                    vc = 255;
                    sc = 0;
                    wc = 128;
                end
                default:
                begin
                    vc = $urandom_range(0, 255);
                    sc = $urandom_range(0, 255);
                    wc = $urandom_range(0, 255);
                end
            endcase
            program_regs(cols, rows, vc, sc, wc);
            if ($urandom_range(0, 2) == 0)
            begin
                program_seed($urandom_range(0, 65535));
            end
            // scene painting, mostly inside the area in use
            for (int k = 0; k < 5; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_op(FUNC_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                            pick_material());
                end
                else
                begin
                    send_op(FUNC_WRITE, $urandom_range(0, used_cols() - 1),
                            $urandom_range(0, used_rows() - 1), pick_material());
                end
            end
            // mixed traffic: passes, reads, touch-ups and the odd spare code
            for (int k = 0; k < 4; k++)
            begin
                op = $urandom_range(0, 99);
                if (op < 35)
                begin
                    send_op(FUNC_PASS, $urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom_range(0, 255));
                end
                else if (op < 70)
                begin
                    send_op(FUNC_READ, $urandom_range(0, used_cols() - 1),
                            $urandom_range(0, used_rows() - 1), $urandom_range(0, 255));
                end
                else if (op < 90)
                begin
                    send_op(FUNC_WRITE, $urandom_range(0, used_cols() - 1),
                            $urandom_range(0, used_rows() - 1), pick_material());
                end
                else
                begin
                    send_op(FUNC_SPARE, $urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom_range(0, 255));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        // known values on every block input from time zero
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.func       = FUNC_WRITE;
        cmd_bus.cell_x     = '0;
        cmd_bus.cell_y     = '0;
        cmd_bus.cell_value = '0;
        err_count          = 0;
        reply_count        = 0;
        gaps_on            = 1'b0;
        stalls_on          = 1'b0;

        // shadow state matches the block right after reset
        cfg_cols   = WIDTH_RST;
        cfg_rows   = HEIGHT_RST;
        code_void  = VOID_RST;
        code_sand  = SAND_RST;
        code_water = WATER_RST;
        tie_state  = SEED_RST;
        for (int i = 0; i < GRID_CELLS; i++)
        begin
            shadow_grid[i] = '0;
        end

        // single reset at the start of the run
        repeat (12)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;

        test_grid_fill();
        test_cell_access();
        test_full_pass();
        test_size_clamp();
        test_tie_break();
        test_water_swap();
        test_equal_codes();
        test_random_scenes();

        drain_replies();
        repeat (TAIL_CYCLES)
        begin
            @(posedge clk);
        end

        if (err_count == 0 && expected_replies.size() == 0)
        begin
            $display("falling_sand_grid_pass regression: pass");
        end
        else
        begin
            $display("falling_sand_grid_pass regression: fail");
        end
        $finish;
    end

endmodule
